// ===== rtl/core/phx_pkg.sv =====
`default_nettype none
package phx_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 53;
  localparam int ROUND_COUNT_DEF = 10;

  localparam logic [WORD_W-1:0] MUL_A  = 32'hD2511F53;
  localparam logic [WORD_W-1:0] MUL_B  = 32'hCD9E8D57;
  localparam logic [WORD_W-1:0] BUMP_A = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] BUMP_B = 32'hBB67AE85;

  // counter words and folded key carried down the round pipeline
  typedef struct packed {
    logic [3:0][WORD_W-1:0] cnt;
    logic [1:0][WORD_W-1:0] key;
  } phx_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/phx_round.sv =====
`default_nettype none
module phx_round (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  phx_pkg::phx_state_t in_state,
  output logic               out_valid,
  output phx_pkg::phx_state_t out_state
);
  import phx_pkg::*;

  logic [2*WORD_W-1:0] prod_a;
  logic [2*WORD_W-1:0] prod_b;
  phx_state_t          state_next;

  assign prod_a = 64'(in_state.cnt[0]) * 64'(MUL_A);
  assign prod_b = 64'(in_state.cnt[2]) * 64'(MUL_B);

  always_comb begin
    state_next.cnt[0] = prod_b[2*WORD_W-1:WORD_W] ^ in_state.cnt[1] ^ in_state.key[0];
    state_next.cnt[1] = prod_b[WORD_W-1:0];
    state_next.cnt[2] = prod_a[2*WORD_W-1:WORD_W] ^ in_state.cnt[3] ^ in_state.key[1];
    state_next.cnt[3] = prod_a[WORD_W-1:0];
    // Weyl bump, wraps mod 2^32
    state_next.key[0] = in_state.key[0] + BUMP_A;
    state_next.key[1] = in_state.key[1] + BUMP_B;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state <= state_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/philox_4x32_block_unit.sv =====
// Registers between the accepting edge and done: one for the key fold, then one per round
// (each round holding two 32x32 multiplies).
// Throughput: one item per cycle; busy is high only while rst is high.
// Reset (rst, synchronous) clears every valid bit; items in flight are dropped.
// done is a one-cycle strobe; the receiver cannot stall.
`default_nettype none
module philox_4x32_block_unit #(
  parameter int ROUND_COUNT = phx_pkg::ROUND_COUNT_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  [phx_pkg::WORD_W-1:0]  key_word0,
  input  wire  [phx_pkg::WORD_W-1:0]  key_word1,
  input  wire  [phx_pkg::WORD_W-1:0]  key_word2,
  input  wire  [phx_pkg::WORD_W-1:0]  key_word3,
  input  wire  [phx_pkg::WORD_W-1:0]  count_word0,
  input  wire  [phx_pkg::WORD_W-1:0]  count_word1,
  input  wire  [phx_pkg::WORD_W-1:0]  count_word2,
  input  wire  [phx_pkg::WORD_W-1:0]  count_word3,
  output logic                        done,
  output logic [phx_pkg::WORD_W-1:0]  rand_word0,
  output logic [phx_pkg::WORD_W-1:0]  rand_word1,
  output logic [phx_pkg::WORD_W-1:0]  rand_word2,
  output logic [phx_pkg::WORD_W-1:0]  rand_word3,
  output logic [phx_pkg::FRAC_W-1:0]  unit_fraction
);
  import phx_pkg::*;

  localparam int FRAC_LO = 2*WORD_W - FRAC_W;

  logic       stage_valid [0:ROUND_COUNT];
  phx_state_t stage_state [0:ROUND_COUNT];
  phx_state_t fold_next;

  assign busy = rst;

  always_comb begin
    fold_next.key[0] = key_word0 ^ key_word2;
    fold_next.key[1] = key_word1 ^ key_word3;
    fold_next.cnt[0] = count_word0;
    fold_next.cnt[1] = count_word1;
    fold_next.cnt[2] = count_word2;
    fold_next.cnt[3] = count_word3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else begin
      stage_valid[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    stage_state[0] <= fold_next;
  end

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    phx_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[r]),
      .in_state  (stage_state[r]),
      .out_valid (stage_valid[r+1]),
      .out_state (stage_state[r+1])
    );
  end

  assign done       = stage_valid[ROUND_COUNT];
  assign rand_word0 = stage_state[ROUND_COUNT].cnt[0];
  assign rand_word1 = stage_state[ROUND_COUNT].cnt[1];
  assign rand_word2 = stage_state[ROUND_COUNT].cnt[2];
  assign rand_word3 = stage_state[ROUND_COUNT].cnt[3];
  // top 53 bits of word0:word1
  assign unit_fraction = {stage_state[ROUND_COUNT].cnt[0],
                          stage_state[ROUND_COUNT].cnt[1][WORD_W-1:FRAC_LO]};

endmodule
`default_nettype wire

// ===== rtl/core/phx_checker.sv =====
`default_nettype none
module phx_checker #(
  parameter int ROUND_COUNT = phx_pkg::ROUND_COUNT_DEF
) (
  input wire                        clk,
  input wire                        rst,
  input wire                        start,
  input wire                        busy,
  input wire                        done,
  input wire [phx_pkg::WORD_W-1:0]  rand_word0,
  input wire [phx_pkg::WORD_W-1:0]  rand_word1,
  input wire [phx_pkg::FRAC_W-1:0]  unit_fraction
);
  import phx_pkg::*;

  localparam int LAT     = ROUND_COUNT + 1;
  localparam int FRAC_LO = 2*WORD_W - FRAC_W;

  // every accepted item comes out on done after the fold register and every round
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item did not produce a result");

  // no result without a matching accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  a_busy_idle: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");

  a_frac: assert property (@(posedge clk) disable iff (rst)
    done |-> (unit_fraction[FRAC_W-1:FRAC_W-WORD_W] == rand_word0 &&
              unit_fraction[FRAC_W-WORD_W-1:0] == rand_word1[WORD_W-1:FRAC_LO]))
    else $error("fraction does not match output words");

endmodule

bind philox_4x32_block_unit phx_checker #(.ROUND_COUNT(ROUND_COUNT)) u_phx_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .rand_word0    (rand_word0),
  .rand_word1    (rand_word1),
  .unit_fraction (unit_fraction)
);
`default_nettype wire
